// ----- hw/rtl/rcad_pkg.sv -----
package rcad_pkg;

    localparam int NUM_BUTTONS = 8;

    localparam int CMD_W     = 2;
    localparam int CH_W      = 11;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int ANGLE_W   = 8;
    localparam int MASK_W    = 8;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 64;

    localparam int CENTER_RAW = 992;
    localparam int PULSE_MID  = 1500;
    localparam int PULSE_MIN  = 1000;
    localparam int PULSE_MAX  = 2000;
    localparam int PULSE_SUM  = 3000;

    localparam int SYM_BASE = 220;
    localparam int SYM_STEP = 48;
    localparam int SYM_TOL  = 24;
    localparam int SYM_LOW  = SYM_BASE - SYM_TOL;
    localparam int K_MAX    = 31;

    localparam int ANGLE_BASE   = -90;
    localparam int ANGLE_STEP   = 30;
    localparam int ANGLE_CENTER = 4;

    localparam logic [CH_W-1:0]      CW_RESET       = 11'h400;
    localparam logic [CH_W-1:0]      STEER_RESET    = CH_W'(PULSE_MID);
    localparam logic [CH_W-1:0]      THROTTLE_RESET = CH_W'(PULSE_MID);
    localparam logic [CH_W-1:0]      BRAKE_RESET    = CH_W'(PULSE_MIN);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = TIMEOUT_W'(100);

    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME  = 2'd0,
        CMD_LOST   = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        SEG_LOW    = 2'd0,
        SEG_MID    = 2'd1,
        SEG_DIFF   = 2'd2,
        SEG_CAMERA = 2'd3
    } seg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [CH_W-1:0]   control_raw;
        logic [CH_W-1:0]   brake_raw;
        logic [CH_W-1:0]   throttle_raw;
        logic [CH_W-1:0]   steer_raw;
        logic [CMD_W-1:0]  cmd;
    } in_item_t;

    typedef struct packed {
        logic                      link_recent;
        logic                      link_valid;
        logic                      rear_diff_locked;
        logic                      front_diff_locked;
        logic [MASK_W-1:0]         button_mask;
        logic [CH_W-1:0]           assembled_word;
        logic signed [ANGLE_W-1:0] camera_angle_deg;
        logic [CH_W-1:0]           brake_us;
        logic [CH_W-1:0]           throttle_us;
        logic [CH_W-1:0]           steer_us;
    } out_item_t;

    // Camera code 0 is treated as the center code.
    function automatic logic signed [ANGLE_W-1:0] camera_angle(input logic [2:0] code);
        int c;
        c = (code == 3'd0) ? ANGLE_CENTER : int'(code);
        return ANGLE_W'(ANGLE_BASE + (c - 1) * ANGLE_STEP);
    endfunction

endpackage

// ----- hw/rtl/rcad_pulse_map.sv -----
module rcad_pulse_map (
    input  logic [rcad_pkg::CH_W-1:0] raw,
    input  logic                      invert,
    output logic [rcad_pkg::CH_W-1:0] pulse
);
    import rcad_pkg::*;

    localparam int CALC_W = 16;

    logic signed [CALC_W-1:0] diff;
    logic signed [CALC_W-1:0] scaled;
    logic signed [CALC_W-1:0] quot;
    logic signed [CALC_W-1:0] width;
    logic signed [CALC_W-1:0] clamped;
    logic signed [CALC_W-1:0] inverted;

    always_comb begin
        diff   = $signed(CALC_W'(raw)) - $signed(CALC_W'(CENTER_RAW));
        scaled = CALC_W'(diff * $signed(CALC_W'(5)));
        // Bias negative values so the arithmetic shift truncates toward zero.
        quot   = (scaled + ((scaled < 0) ? $signed(CALC_W'(7)) : $signed(CALC_W'(0)))) >>> 3;
        width  = quot + $signed(CALC_W'(PULSE_MID));
        if (width < $signed(CALC_W'(PULSE_MIN))) begin
            clamped = $signed(CALC_W'(PULSE_MIN));
        end else if (width > $signed(CALC_W'(PULSE_MAX))) begin
            clamped = $signed(CALC_W'(PULSE_MAX));
        end else begin
            clamped = width;
        end
        // The mirrored value stays inside the pulse range, so no second clamp.
        inverted = $signed(CALC_W'(PULSE_SUM)) - clamped;
        pulse    = invert ? CH_W'(inverted) : CH_W'(clamped);
    end

endmodule

// ----- hw/rtl/rcad_symbol_decode.sv -----
module rcad_symbol_decode (
    input  logic [rcad_pkg::CH_W-1:0] raw,
    input  logic [rcad_pkg::CH_W-1:0] word_in,
    output logic [rcad_pkg::CH_W-1:0] word_out
);
    import rcad_pkg::*;

    // The step of 48 is 16 times 3; the divide by 3 uses 171/512, exact below 512.
    localparam int RECIP       = 171;
    localparam int RECIP_SHIFT = 9;
    localparam int K_W         = 6;
    localparam int PROD_W      = 15;

    logic [CH_W-1:0]   offset;
    logic [PROD_W-1:0] prod;
    logic [K_W-1:0]    k;
    logic [CH_W-1:0]   rem;
    logic [CH_W-1:0]   err;
    logic              sym_ok;
    logic [2:0]        pay;

    always_comb begin
        offset = raw - CH_W'(SYM_LOW);
        prod   = PROD_W'(PROD_W'(offset[CH_W-1:4]) * PROD_W'(RECIP));
        k      = prod[RECIP_SHIFT +: K_W];
        rem    = offset - CH_W'(CH_W'(k) * CH_W'(SYM_STEP));
        err    = (rem >= CH_W'(SYM_TOL)) ? rem - CH_W'(SYM_TOL) : CH_W'(SYM_TOL) - rem;
        sym_ok = (raw >= CH_W'(SYM_LOW)) && (k <= K_W'(K_MAX)) && (err <= CH_W'(SYM_TOL));
        pay    = k[2:0];

        word_out = word_in;
        if (sym_ok) begin
            unique case (seg_t'(k[4:3]))
                SEG_LOW:    word_out[2:0]  = pay;
                SEG_MID:    word_out[5:3]  = pay;
                SEG_DIFF:   word_out[7:6]  = pay[1:0];
                SEG_CAMERA: word_out[10:8] = pay;
            endcase
        end
    end

endmodule

// ----- hw/rtl/rc_channel_to_actuator_decoder_core.sv -----
// Path: an item waits in the input register, then its result goes to the result register.
// Throughput: one item per cycle unless m_tready stalls; input and result registers form a
// two-entry pipeline, so the input side takes one more item while a result waits.
// Reset: synchronous, active-low aresetn empties both stages, restores the control
// word, pulse widths, frame time, link flag and the timeout register to their defaults.
module rc_channel_to_actuator_decoder_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rcad_pkg::TIMEOUT_W-1:0] cfg_data,   // recency timeout in milliseconds
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // steer_raw, throttle_raw, brake_raw, control_raw, now_ms, zero fill
    input  logic [rcad_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rcad_pkg::S_TUSER_W-1:0] s_tuser,    // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // steer_us, throttle_us, brake_us, camera_angle_deg, assembled_word, button_mask,
    // front_diff_locked, rear_diff_locked, link_valid, link_recent
    output logic [rcad_pkg::M_TDATA_W-1:0] m_tdata
);
    import rcad_pkg::*;

    localparam logic [CH_W-1:0] BUTTON_SEL = CH_W'((1 << NUM_BUTTONS) - 1);

    logic                 in_valid_reg;
    in_item_t             in_item_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;
    out_item_t            out_item_next;

    logic [CH_W-1:0]      cw_reg,       cw_next;
    logic [CH_W-1:0]      steer_reg,    steer_next;
    logic [CH_W-1:0]      throttle_reg, throttle_next;
    logic [CH_W-1:0]      brake_reg,    brake_next;
    logic [TIME_W-1:0]    last_time_reg, last_time_next;
    logic                 link_valid_reg, link_valid_next;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic [CH_W-1:0]      steer_pulse, throttle_pulse, brake_pulse, cw_decoded;
    logic [TIME_W-1:0]    age;
    logic [CH_W-1:0]      buttons;
    logic                 advance;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(out_item_reg);

    rcad_pulse_map u_steer (
        .raw    (in_item_reg.steer_raw),
        .invert (1'b1),
        .pulse  (steer_pulse)
    );

    rcad_pulse_map u_throttle (
        .raw    (in_item_reg.throttle_raw),
        .invert (1'b0),
        .pulse  (throttle_pulse)
    );

    rcad_pulse_map u_brake (
        .raw    (in_item_reg.brake_raw),
        .invert (1'b0),
        .pulse  (brake_pulse)
    );

    rcad_symbol_decode u_symbol (
        .raw      (in_item_reg.control_raw),
        .word_in  (cw_reg),
        .word_out (cw_decoded)
    );

    always_comb begin
        cw_next         = cw_reg;
        steer_next      = steer_reg;
        throttle_next   = throttle_reg;
        brake_next      = brake_reg;
        last_time_next  = last_time_reg;
        link_valid_next = link_valid_reg;
        unique case (in_item_reg.cmd)
            CMD_FRAME: begin
                cw_next         = cw_decoded;
                steer_next      = steer_pulse;
                throttle_next   = throttle_pulse;
                brake_next      = brake_pulse;
                last_time_next  = in_item_reg.now_ms;
                link_valid_next = 1'b1;
            end
            CMD_LOST: begin
                link_valid_next = 1'b0;
            end
            default: begin
                // Status check and the unused code leave the state alone.
            end
        endcase
    end

    always_comb begin
        age     = in_item_reg.now_ms - last_time_next;
        buttons = cw_next & BUTTON_SEL;
        out_item_next.steer_us          = steer_next;
        out_item_next.throttle_us       = throttle_next;
        out_item_next.brake_us          = brake_next;
        out_item_next.camera_angle_deg  = camera_angle(cw_next[10:8]);
        out_item_next.assembled_word    = cw_next;
        out_item_next.button_mask       = buttons[MASK_W-1:0];
        out_item_next.front_diff_locked = cw_next[6];
        out_item_next.rear_diff_locked  = cw_next[7];
        out_item_next.link_valid        = link_valid_next;
        out_item_next.link_recent       = link_valid_next && (age <= TIME_W'(timeout_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cw_reg         <= CW_RESET;
            steer_reg      <= STEER_RESET;
            throttle_reg   <= THROTTLE_RESET;
            brake_reg      <= BRAKE_RESET;
            last_time_reg  <= '0;
            link_valid_reg <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    cw_reg         <= cw_next;
                    steer_reg      <= steer_next;
                    throttle_reg   <= throttle_next;
                    brake_reg      <= brake_next;
                    last_time_reg  <= last_time_next;
                    link_valid_reg <= link_valid_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= {s_tdata[TIME_W + 4*CH_W - 1:0], s_tuser};
        end
        if (advance && in_valid_reg) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

// ----- hw/rtl/rcad_checker.sv -----
module rcad_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rcad_pkg::M_TDATA_W-1:0] m_tdata
);
    import rcad_pkg::*;

    out_item_t res;
    assign res = out_item_t'(m_tdata);

    // A result that is held back stays put until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_recent_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.link_recent |-> res.link_valid)
        else $error("link recent without link valid");

    a_pulse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.steer_us >= CH_W'(PULSE_MIN) && res.steer_us <= CH_W'(PULSE_MAX)
                  && res.brake_us >= CH_W'(PULSE_MIN) && res.brake_us <= CH_W'(PULSE_MAX))
        else $error("pulse width out of range");

    a_word_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.camera_angle_deg == camera_angle(res.assembled_word[10:8])
                  && res.front_diff_locked == res.assembled_word[6]
                  && res.rear_diff_locked == res.assembled_word[7])
        else $error("decoded fields disagree with the control word");

endmodule

bind rc_channel_to_actuator_decoder_core rcad_checker u_rcad_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
